FILE: hw/rtl/lprd_pkg.sv
// ----------------------------------------------------------------------------
// lprd_pkg: shared types and constants of the led pwm row driver
// Item codes, the queued item record, back-end states and the decay rule.
// ----------------------------------------------------------------------------
package lprd_pkg;

   // command codes as they arrive on the request port
   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_ADVANCE = 2'd1,
      CMD_FRAME   = 2'd2
   } cmd_type;

   // back-end sequencer states
   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_FRAME = 1'b1
   } state_type;

   localparam int unsigned ROW_W         = 32;
   localparam logic [5:0]  PWM_TOP_RESET = 6'd31;

   // classified item as it sits in the queue
   typedef struct packed {
      cmd_type    command;
      logic [4:0] led_index;
      logic [7:0] level;
      logic [4:0] shift_end;   // already saturated to the last led
   } item_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // decayed level of led 0: n > 2 ? n - n/4 - 2 : 0
   function automatic logic [7:0] decay_level(input logic [7:0] n);
      logic [7:0] r;
      r = 8'd0;
      if (n > 8'd2) begin
         r = n - {2'b00, n[7:2]} - 8'd2;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/lprd_front.sv
// ----------------------------------------------------------------------------
// lprd_front: request intake and item queue
// Accepts items, drops the ones with no effect, saturates the shift end and
// keeps up to two items for the back end.
// ----------------------------------------------------------------------------
module lprd_front #(
   parameter int unsigned LED_COUNT = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_command,
   input  logic [4:0]          req_led_index,
   input  logic [7:0]          req_level,
   input  logic [4:0]          req_shift_end,
   output lprd_pkg::head_type  head,
   input  logic                pop
);

   lprd_pkg::item_type queue_ff [2];
   logic [1:0]         count_ff, count_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic               wr_ptr_ff, wr_ptr_in;
   logic               accept;
   logic               keep;
   lprd_pkg::item_type incoming;

   assign busy   = (count_ff == 2'd2);
   assign accept = start && !busy;

   // classify the request
   always_comb begin
      incoming.command   = lprd_pkg::CMD_WRITE;
      incoming.led_index = req_led_index;
      incoming.level     = req_level;
      incoming.shift_end = req_shift_end;
      keep               = 1'b0;
      if (32'(req_shift_end) > LED_COUNT - 1) begin
         incoming.shift_end = 5'(LED_COUNT - 1);
      end
      unique case (req_command)
         lprd_pkg::CMD_WRITE: begin
            incoming.command = lprd_pkg::CMD_WRITE;
            keep             = (32'(req_led_index) < LED_COUNT);
         end
         lprd_pkg::CMD_ADVANCE: begin
            incoming.command = lprd_pkg::CMD_ADVANCE;
            keep             = 1'b1;
         end
         lprd_pkg::CMD_FRAME: begin
            incoming.command = lprd_pkg::CMD_FRAME;
            keep             = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // queue pointers and fill level
   always_comb begin
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      if (accept && keep) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if ((accept && keep) && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!(accept && keep) && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (accept && keep) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = queue_ff[rd_ptr_ff];

endmodule

FILE: hw/rtl/lprd_back.sv
// ----------------------------------------------------------------------------
// lprd_back: level store and row sequencer
// Applies writes and advance shifts to the led levels and emits the compare
// rows of a frame, one per cycle.
// ----------------------------------------------------------------------------
module lprd_back #(
   parameter int unsigned LED_COUNT = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [5:0]          pwm_top,
   input  lprd_pkg::head_type  head,
   output logic                pop,
   output logic                rsp_valid,
   output logic [31:0]         rsp_row_bits,
   output logic                rsp_last_row
);

   localparam int unsigned MASK_N = (LED_COUNT < lprd_pkg::ROW_W) ? LED_COUNT : lprd_pkg::ROW_W;

   lprd_pkg::state_type state_ff, state_in;
   logic [5:0]          row_ff, row_in;
   logic [7:0]          levels_ff [LED_COUNT];
   logic [7:0]          levels_in [LED_COUNT];
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         out_bits_ff, out_bits_in;
   logic                out_last_ff, out_last_in;
   logic [31:0]         mask;
   logic                last;
   logic                do_write;
   logic                do_advance;
   logic                end_is_last;

   // compare row for the current row counter
   always_comb begin
      mask = 32'd0;
      for (int i = 0; i < MASK_N; i++) begin
         mask[i] = (levels_ff[i] > {2'b00, row_ff});
      end
   end

   assign last = ((row_ff + 6'd1) == pwm_top);

   // sequencer: next state and outputs
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      pop          = 1'b0;
      do_write     = 1'b0;
      do_advance   = 1'b0;
      out_valid_in = 1'b0;
      out_bits_in  = mask;
      out_last_in  = last;
      unique case (state_ff)
         lprd_pkg::ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.item.command)
                  lprd_pkg::CMD_WRITE:   do_write   = 1'b1;
                  lprd_pkg::CMD_ADVANCE: do_advance = 1'b1;
                  lprd_pkg::CMD_FRAME: begin
                     row_in = 6'd0;
                     if (pwm_top != 6'd0) begin
                        state_in = lprd_pkg::ST_FRAME;
                     end
                  end
                  default: ;
               endcase
            end
         end
         lprd_pkg::ST_FRAME: begin
            out_valid_in = 1'b1;
            row_in       = row_ff + 6'd1;
            if (last) begin
               row_in   = 6'd0;
               state_in = lprd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lprd_pkg::ST_IDLE;
         end
      endcase
   end

   // per-led update for write and advance
   assign end_is_last = (32'(head.item.shift_end) == LED_COUNT - 1);

   always_comb begin
      for (int i = 0; i < LED_COUNT; i++) begin
         levels_in[i] = levels_ff[i];
         if (do_write && (32'(head.item.led_index) == 32'(i))) begin
            levels_in[i] = head.item.level;
         end
         if (do_advance) begin
            if (i == 0) begin
               levels_in[i] = lprd_pkg::decay_level(levels_ff[0]);
            end else if (32'(i) <= 32'(head.item.shift_end)) begin
               levels_in[i] = levels_ff[i-1];
               if ((i == LED_COUNT - 1) && end_is_last) begin
                  levels_in[i] = levels_ff[i-1] + {1'b0, levels_ff[i][7:1]};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lprd_pkg::ST_IDLE;
         row_ff       <= 6'd0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < LED_COUNT; i++) begin
            levels_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < LED_COUNT; i++) begin
            levels_ff[i] <= levels_in[i];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      out_bits_ff <= out_bits_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_row_bits = out_bits_ff;
   assign rsp_last_row = out_valid_ff && out_last_ff;

endmodule

FILE: hw/rtl/led_pwm_rows_with_decay_shift.sv
// ----------------------------------------------------------------------------
// led_pwm_rows_with_decay_shift: pwm row generator with a decaying led chain
// Write and advance change the levels as the item leaves the queue; a frame
// emits pwm_top rows, one per cycle, after the state and result registers.
// Throughput: one item per cycle into a two-entry queue while busy is low; the
// back end drains writes and advances at one per cycle, none during a frame.
// Synchronous reset clears all levels to zero, empties the queue and sets
// pwm_top to 31. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module led_pwm_rows_with_decay_shift #(
   parameter int unsigned LED_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [4:0]  req_led_index,
   input  logic [7:0]  req_level,
   input  logic [4:0]  req_shift_end,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data,
   output logic        rsp_valid,
   output logic [31:0] rsp_row_bits,
   output logic        rsp_last_row
);

   logic [5:0]         pwm_top_ff;
   lprd_pkg::head_type head;
   logic               pop;

   // pwm row count register
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_top_ff <= lprd_pkg::PWM_TOP_RESET;
      end else if (csr_write_enable) begin
         pwm_top_ff <= csr_write_data;
      end
   end

   lprd_front #(
      .LED_COUNT (LED_COUNT)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_led_index (req_led_index),
      .req_level     (req_level),
      .req_shift_end (req_shift_end),
      .head          (head),
      .pop           (pop)
   );

   lprd_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pwm_top      (pwm_top_ff),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_row_bits (rsp_row_bits),
      .rsp_last_row (rsp_last_row)
   );

   // rows of a frame come back to back until the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_row |=> rsp_valid)
      else $error("frame rows not contiguous");

   // a frame ends with a gap before any further row
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_row |=> !rsp_valid)
      else $error("row emitted right after the last row");

   // nothing comes out in the cycle after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // the queue never pops while empty
   assert property (@(posedge clock) disable iff (reset) pop |-> head.valid)
      else $error("pop from empty queue");

endmodule
